>>> rtl/cps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Shared widths and constants of the challenge position sampler.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int POS_W        = 8;   // position and draw byte width
    localparam int SPAN_W       = 9;   // modulus width, holds up to 256
    localparam int MOD_BITS     = 2;   // dividend bits retired per cycle
    localparam int MOD_CYCLES   = POS_W / MOD_BITS;
    localparam int MOD_STEP_W   = $clog2(MOD_CYCLES);

endpackage : cps_pkg
`default_nettype wire

>>> rtl/cps_mod_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_mod_unit
// Restoring remainder unit: dividend modulo divisor, two bits per cycle.
// ----------------------------------------------------------------------------
module cps_mod_unit
    import cps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [POS_W-1:0]  dividend,
    input  wire logic [SPAN_W-1:0] divisor,
    output logic                   done,
    output logic [SPAN_W-1:0]      remainder
);

    logic [POS_W-1:0]      dvd_reg, dvd_next;
    logic [SPAN_W-1:0]     dvs_reg;
    logic [SPAN_W-1:0]     rem_reg, rem_next;
    logic [MOD_STEP_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // The partial remainder stays below the divisor, so it fits in eight bits
    // before each shift.
    always_comb begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        for (int i = 0; i < MOD_BITS; i++) begin
            rem_next = {rem_next[POS_W-1:0], dvd_next[POS_W-1]};
            dvd_next = {dvd_next[POS_W-2:0], 1'b0};
            if (rem_next >= dvs_reg) begin
                rem_next = rem_next - dvs_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                done_reg <= (step_reg == MOD_STEP_W'(MOD_CYCLES - 1));
                if (step_reg == MOD_STEP_W'(MOD_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule : cps_mod_unit
`default_nettype wire

>>> rtl/challenge_position_sampler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// challenge_position_sampler_core
// Picks the nonzero positions of a sparse challenge from a stream of draw bytes.
// ----------------------------------------------------------------------------
// Usage: each slave word carries one draw byte in s_tdata and a start flag in
// s_tuser. A set start flag restores the identity bag and clears the draw
// count before that byte is used. Draw k takes slot byte mod (NUM_COEFFS - k)
// of the bag, sends the position held there as one master word and moves the
// last live slot into it. m_tlast marks the final position of a challenge;
// after that, words are accepted and dropped until the next start flag.
// Timing: one word is in flight at a time. A draw passes through the remainder
// unit (two dividend bits a cycle), the bag read, the write-back and the hand-off
// of the result to the output register, where it appears as s_tready rises. A
// dropped word is taken without leaving the idle state. The output register
// lets the next word be accepted while a result waits; if the receiver stalls
// longer, the core holds the finished result and lowers s_tready until the
// output register frees.
// Reset clears the draw count, the bag valid bits (an invalid slot reads as its
// own index) and both channels; the bag memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module challenge_position_sampler_core
    import cps_pkg::*;
#(
    parameter int NUM_COEFFS = 256,
    parameter int NUM_ONES   = 40
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [POS_W-1:0] s_tdata,   // [7:0] draw_byte
    input  wire logic             s_tuser,   // [0] start_req
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [POS_W-1:0]      m_tdata,   // [7:0] position
    output logic                  m_tlast
);

    localparam int DRAW_LIMIT = (NUM_ONES < NUM_COEFFS) ? NUM_ONES : NUM_COEFFS;
    localparam int CNT_W      = $clog2(DRAW_LIMIT + 1);
    localparam int ADDR_W     = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_WRITE = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    taken;
    logic [NUM_COEFFS-1:0] valid_reg;
    logic [ADDR_W-1:0]   slot_reg;
    logic [ADDR_W-1:0]   tail_reg;
    logic [SPAN_W-1:0]   span;
    logic                accept;
    logic                draw_ok;
    logic                out_free;

    logic [POS_W-1:0]    bag_mem [NUM_COEFFS];
    logic [POS_W-1:0]    rd_slot_reg, rd_tail_reg;
    logic                vld_slot_reg, vld_tail_reg;
    logic [POS_W-1:0]    picked;
    logic [POS_W-1:0]    moved;
    logic [POS_W-1:0]    pick_reg;
    logic                last_reg;

    logic                mod_start;
    logic                mod_done;
    logic [SPAN_W-1:0]   mod_rem;
    logic [ADDR_W-1:0]   rem_slot;

    logic                m_tvalid_reg;
    logic [POS_W-1:0]    m_tdata_reg;
    logic                m_tlast_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign taken     = s_tuser ? '0 : cnt_reg;
    assign draw_ok   = (int'(taken) < DRAW_LIMIT);
    assign span      = SPAN_W'(NUM_COEFFS) - SPAN_W'(taken);
    assign mod_start = accept && draw_ok;
    assign rem_slot  = mod_rem[ADDR_W-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;

    cps_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_tdata),
        .divisor   (span),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // A slot never written since the last restore reads as its own index.
    assign picked = vld_slot_reg ? rd_slot_reg : POS_W'(slot_reg);
    assign moved  = vld_tail_reg ? rd_tail_reg : POS_W'(tail_reg);

    // Bag memory: two read ports when the remainder is ready, one write port.
    always_ff @(posedge aclk) begin
        if (state_reg == S_DIV && mod_done) begin
            rd_slot_reg <= bag_mem[rem_slot];
            rd_tail_reg <= bag_mem[tail_reg];
        end
        if (state_reg == S_WRITE) begin
            bag_mem[slot_reg] <= moved;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tail_reg <= ADDR_W'(span - 1'b1);
        end
        if (state_reg == S_DIV && mod_done) begin
            slot_reg     <= rem_slot;
            vld_slot_reg <= valid_reg[rem_slot];
            vld_tail_reg <= valid_reg[tail_reg];
        end
        if (state_reg == S_WRITE) begin
            pick_reg <= picked;
            last_reg <= (int'(cnt_reg) + 1 == DRAW_LIMIT);
        end
        if (state_reg == S_EMIT && out_free) begin
            m_tdata_reg <= pick_reg;
            m_tlast_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_tuser) begin
                            cnt_reg   <= '0;
                            valid_reg <= '0;
                        end
                        if (draw_ok) begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (mod_done) begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    valid_reg[slot_reg] <= 1'b1;
                    cnt_reg             <= cnt_reg + 1'b1;
                    state_reg           <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule : challenge_position_sampler_core
`default_nettype wire

>>> sim/challenge_position_sampler_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// challenge_position_sampler_core_tb
// Self-checking bench for the challenge position sampler.
// ----------------------------------------------------------------------------
// A queue of draw words feeds a clocked driver. Each accepted word runs through
// a local model of the slot table, and any pick it yields is queued. A clocked
// monitor compares every result word with the oldest queued pick.
// The bench opens with a few hand-picked words. Most of the random traffic is
// whole challenges followed by words the core should drop. The rest is
// challenges cut short by a fresh start, and loose noise.
// It runs through four back-pressure phases: none, sender gaps, receiver
// stalls, and both.
// ----------------------------------------------------------------------------
module challenge_position_sampler_core_tb
    import cps_pkg::*;
();

    localparam int NUM_COEFFS   = 256;
    localparam int NUM_ONES     = 40;
    localparam int DRAW_LIMIT   = (NUM_ONES < NUM_COEFFS) ? NUM_ONES : NUM_COEFFS;
    localparam int PICK_GOAL    = 1900;
    localparam int DRAIN_CYCLES = 20;
    localparam int SEND_IDLE[4] = '{0, 86, 0, 27};
    localparam int RECV_STALL[4] = '{0, 0, 86, 27};

    typedef struct {
        logic [POS_W-1:0] draw;
        logic             start;
    } draw_word_t;

    typedef struct {
        logic [POS_W-1:0] position;
        logic             last;
    } challenge_pick_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [POS_W-1:0] s_tdata  = '0;   // [7:0] draw_byte
    logic             s_tuser  = 1'b0; // [0] start_req
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [POS_W-1:0] m_tdata;         // [7:0] position
    logic             m_tlast;

    draw_word_t       pending_words[$];
    challenge_pick_t  expected_picks[$];
    challenge_pick_t  oldest_pick;
    draw_word_t       next_word;

    logic [POS_W-1:0] slot_table[NUM_COEFFS];
    int               picks_made;
    int               planned_draws;
    int               planned_picks;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               error_count;

    challenge_position_sampler_core #(
        .NUM_COEFFS (NUM_COEFFS),
        .NUM_ONES   (NUM_ONES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH: %s", what);
        error_count++;
    endtask

    task automatic refill_slots();
        for (int i = 0; i < NUM_COEFFS; i++)
            slot_table[i] = i[POS_W-1:0];
        picks_made = 0;
    endtask

    // Draw k takes slot draw mod (NUM_COEFFS - k), then the last live slot is
    // moved into the hole. Once the challenge is full the word is dropped.
    task automatic pick_position(input logic [POS_W-1:0] draw, input logic start);
        int span;
        int slot;
        challenge_pick_t pick;
        if (start)
            refill_slots();
        if (picks_made < DRAW_LIMIT) begin
            span = NUM_COEFFS - picks_made;
            slot = int'(draw) % span;
            pick.position = slot_table[slot];
            slot_table[slot] = slot_table[span - 1];
            picks_made++;
            pick.last = (picks_made == DRAW_LIMIT);
            expected_picks.push_back(pick);
        end
    endtask

    task automatic queue_word(input logic [POS_W-1:0] draw, input logic start);
        draw_word_t w;
        w.draw  = draw;
        w.start = start;
        pending_words.push_back(w);
        if (start)
            planned_draws = 0;
        if (planned_draws < DRAW_LIMIT) begin
            planned_draws++;
            planned_picks++;
        end
    endtask

    // Leans a little towards the extremes of the byte range.
    function automatic logic [POS_W-1:0] random_draw();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return '1;
        return POS_W'($urandom_range(255));
    endfunction

    task automatic queue_challenge();
        int kind;
        int cut;
        kind = $urandom_range(99);
        if (kind < 80) begin
            queue_word(random_draw(), 1'b1);
            repeat (DRAW_LIMIT - 1) queue_word(random_draw(), 1'b0);
            // Words after the final pick must be dropped.
            repeat ($urandom_range(3)) queue_word(random_draw(), 1'b0);
        end else if (kind < 92) begin
            // Cut short: the next challenge restarts the table mid-way.
            cut = $urandom_range(DRAW_LIMIT - 1, 1);
            queue_word(random_draw(), 1'b1);
            repeat (cut - 1) queue_word(random_draw(), 1'b0);
        end else begin
            repeat ($urandom_range(6, 1))
                queue_word(random_draw(), 1'($urandom_range(1)));
        end
    endtask

    // Driver: the model sees each word at the edge where it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            refill_slots();
        end else begin
            if (s_tvalid && s_tready)
                pick_position(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.draw;
                    s_tuser  <= next_word.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch($sformatf("unexpected position %0d last %0b",
                                              m_tdata, m_tlast));
                end else begin
                    oldest_pick = expected_picks.pop_front();
                    if (m_tdata !== oldest_pick.position)
                        report_mismatch($sformatf("position %0d, wanted %0d",
                                                  m_tdata, oldest_pick.position));
                    if (m_tlast !== oldest_pick.last)
                        report_mismatch($sformatf("last %0b, wanted %0b at position %0d",
                                                  m_tlast, oldest_pick.last, m_tdata));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        error_count    = 0;
        planned_draws  = 0;
        planned_picks  = 0;
        send_idle_pct  = SEND_IDLE[0];
        recv_stall_pct = RECV_STALL[0];
        refill_slots();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Straight out of reset no start word is needed.
        queue_word(8'd255, 1'b0);
        queue_word(8'd0,   1'b0);
        queue_word(8'd255, 1'b0);
        queue_word(8'd1,   1'b0);
        // A start word restores the table and is used as the first draw.
        queue_word(8'd0,   1'b1);
        queue_word(8'd255, 1'b1);
        queue_word(8'd254, 1'b0);
        queue_word(8'd253, 1'b0);
        queue_word(8'd128, 1'b0);
        queue_word(8'd127, 1'b0);
        queue_word(8'd85,  1'b0);
        queue_word(8'd170, 1'b0);
        queue_word(8'd255, 1'b1);
        queue_word(8'd255, 1'b0);
        queue_word(8'd255, 1'b0);
        queue_word(8'd0,   1'b0);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            while (planned_picks < (p + 1) * PICK_GOAL / 4)
                queue_challenge();
            while (pending_words.size() != 0)
                @(posedge aclk);
        end

        while (s_tvalid || expected_picks.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_picks.size() != 0)
            report_mismatch($sformatf("%0d positions never arrived", expected_picks.size()));

        if (error_count == 0)
            $display("challenge_position_sampler_core test passed");
        else
            $display("challenge_position_sampler_core test failed");
        $finish;
    end

    // Timeout set far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("challenge_position_sampler_core test failed");
        $finish;
    end

endmodule : challenge_position_sampler_core_tb
`default_nettype wire
